// ===== rtl/iirl_pkg.sv =====
// Package for the indexed insert/remove list unit.
// Holds sizes, operation and status codes, and the command struct sent to the cell chain.
// No dependencies.
`default_nettype none

package iirl_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;

	// Widths of the fixed stream fields
	localparam int OP_W     = 3;
	localparam int POS_W    = 7;
	localparam int ITEM_W   = 32;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	// Compare width wide enough for both the position field and the fill count
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Read-out OR tree: first level registered in groups
	localparam int GROUPS   = 8;
	localparam int GRP_SIZE = (CAPACITY + GROUPS - 1) / GROUPS;
	localparam int TAP_N    = GROUPS * GRP_SIZE;

	localparam int IN_TDATA_W  = ((OP_W + POS_W + ITEM_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((VALUE_W + STATUS_W + COUNT_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_REPLACE = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_READ    = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell in the execute cycle
	typedef struct packed {
		logic                  ins;
		logic                  rep;
		logic                  rem;
		logic [CMP_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] item;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_insert_remove_list_unit.sv =====
// Indexed insert/remove list unit, top level.
// Ordered list of up to CAPACITY words held in a row of shifting cells.
//
// Input stream (s_*): one transaction carries operation, position and item.
// Operations: insert at 0..count, replace, remove, read, clear.
// Output stream (m_*): one transaction per input transaction with the
// returned value (zero unless remove/read succeeded), status
// (ok, out of range, full) and the count after the operation.
//
// Timing: an item moves from acceptance to the result landing in the output
// register through a command state where all cells shift in parallel and the
// matching entry is tapped into the first OR tree level, then a reduce state
// that finishes the OR tree over the registered group results. The input is
// ready only while idle, so a new item is not accepted until the previous one
// leaves reduce; insert and remove shifts finish within the command state.
// The output register decouples the sides: a new item is accepted while a
// result waits; if the receiver stalls, the following item parks after its
// command cycle until the output register frees up.
// Reset empties the list (count zero); cell contents are not cleared.
// Depends on iirl_pkg, iirl_chain, iirl_cell.
`default_nettype none

module indexed_insert_remove_list_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// s_tdata: operation[2:0], position[9:3], item[41:10], zero pad [47:42]
	input  wire logic [iirl_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// m_tdata: value[31:0], status[33:32], count[40:34], zero pad [47:41]
	output logic      [iirl_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_REDUCE = 3'b100
	} state_t;

	state_t state_q;

	logic [iirl_pkg::OP_W-1:0]     op_q;
	logic [iirl_pkg::POS_W-1:0]    pos_q;
	logic [iirl_pkg::ITEM_W-1:0]   item_q;
	logic [iirl_pkg::CNT_W-1:0]    used_q;
	logic [iirl_pkg::CNT_W-1:0]    used_d;
	logic [iirl_pkg::STATUS_W-1:0] status_d;
	logic [iirl_pkg::STATUS_W-1:0] status_q;
	logic                          take_d;
	logic                          take_q;

	logic                          out_valid_q;
	logic [iirl_pkg::VALUE_W-1:0]  out_value_q;
	logic [iirl_pkg::STATUS_W-1:0] out_status_q;
	logic [iirl_pkg::COUNT_W-1:0]  out_count_q;

	logic [iirl_pkg::CMP_W-1:0]      pos_e;
	logic [iirl_pkg::CMP_W-1:0]      used_e;
	logic                            exec;
	logic                            out_free;
	logic                            in_fire;
	iirl_pkg::cell_cmd_t             cmd;
	logic [iirl_pkg::DATA_WIDTH-1:0] rd_value;

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign exec     = (state_q == S_EXEC);
	assign out_free = !out_valid_q || m_tready;
	assign pos_e    = iirl_pkg::CMP_W'(pos_q);
	assign used_e   = iirl_pkg::CMP_W'(used_q);

	always_comb begin
		cmd.ins  = 1'b0;
		cmd.rep  = 1'b0;
		cmd.rem  = 1'b0;
		cmd.pos  = pos_e;
		cmd.item = iirl_pkg::DATA_WIDTH'(item_q);
		used_d   = used_q;
		status_d = iirl_pkg::ST_OK;
		take_d   = 1'b0;
		unique case (op_q)
			iirl_pkg::OP_INSERT: begin
				if (pos_e > used_e) begin
					status_d = iirl_pkg::ST_RANGE;
				end else if (used_q == iirl_pkg::CNT_W'(iirl_pkg::CAPACITY)) begin
					status_d = iirl_pkg::ST_FULL;
				end else begin
					cmd.ins = exec;
					used_d  = used_q + 1'b1;
				end
			end
			iirl_pkg::OP_REPLACE: begin
				if (pos_e >= used_e) begin
					status_d = iirl_pkg::ST_RANGE;
				end else begin
					cmd.rep = exec;
				end
			end
			iirl_pkg::OP_REMOVE: begin
				if (pos_e >= used_e) begin
					status_d = iirl_pkg::ST_RANGE;
				end else begin
					cmd.rem = exec;
					take_d  = 1'b1;
					used_d  = used_q - 1'b1;
				end
			end
			iirl_pkg::OP_READ: begin
				if (pos_e >= used_e) begin
					status_d = iirl_pkg::ST_RANGE;
				end else begin
					take_d = 1'b1;
				end
			end
			iirl_pkg::OP_CLEAR: begin
				used_d = '0;
			end
			default: begin
				status_d = iirl_pkg::ST_RANGE;
			end
		endcase
	end

	iirl_chain u_chain (
		.clk      (clk),
		.cmd      (cmd),
		.capture  (exec),
		.rd_value (rd_value)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= s_tdata[2:0];
			pos_q  <= s_tdata[9:3];
			item_q <= s_tdata[41:10];
		end
		if (exec) begin
			status_q <= status_d;
			take_q   <= take_d;
		end
		if ((state_q == S_REDUCE) && out_free) begin
			out_value_q  <= take_q ? iirl_pkg::VALUE_W'(rd_value) : '0;
			out_status_q <= status_q;
			out_count_q  <= iirl_pkg::COUNT_W'(used_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					used_q  <= used_d;
					state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((state_q == S_REDUCE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = iirl_pkg::OUT_TDATA_W'({out_count_q, out_status_q, out_value_q});

	// Fill count never passes the number of cells
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= iirl_pkg::CNT_W'(iirl_pkg::CAPACITY))
		else $error("list count above capacity");

	// Accepted transaction goes straight to the command cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_EXEC))
		else $error("accepted transaction did not execute");

	// Clear empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && (op_q == iirl_pkg::OP_CLEAR)) |=> (used_q == '0))
		else $error("clear left entries");

	// A failed operation never returns data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != iirl_pkg::ST_OK)) |-> (out_value_q == '0))
		else $error("failed transaction returned data");

endmodule

`default_nettype wire

// ===== rtl/iirl_cell.sv =====
// One storage cell of the list: holds one entry and shifts to/from its neighbors.
// Depends on iirl_pkg.
`default_nettype none

module iirl_cell (
	input  wire logic                           clk,
	input  wire logic [iirl_pkg::CMP_W-1:0]     idx,
	input  wire iirl_pkg::cell_cmd_t            cmd,
	input  wire logic [iirl_pkg::DATA_WIDTH-1:0] lower,
	input  wire logic [iirl_pkg::DATA_WIDTH-1:0] upper,
	output logic      [iirl_pkg::DATA_WIDTH-1:0] data,
	output logic      [iirl_pkg::DATA_WIDTH-1:0] tap
);

	logic [iirl_pkg::DATA_WIDTH-1:0] data_q;
	logic                            hit;
	logic                            above;

	assign hit   = (idx == cmd.pos);
	assign above = (idx > cmd.pos);

	always_ff @(posedge clk) begin
		if ((cmd.ins || cmd.rep) && hit) begin
			data_q <= cmd.item;
		end else if (cmd.ins && above) begin
			data_q <= lower;
		end else if (cmd.rem && (hit || above)) begin
			data_q <= upper;
		end
	end

	assign data = data_q;
	// Pre-update contents, so remove returns the entry before the gap closes
	assign tap  = hit ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/iirl_chain.sv =====
// Row of list cells with neighbor shifting and a registered OR tree for read-out.
// Depends on iirl_pkg and iirl_cell.
`default_nettype none

module iirl_chain (
	input  wire logic                            clk,
	input  wire iirl_pkg::cell_cmd_t             cmd,
	input  wire logic                            capture,
	output logic      [iirl_pkg::DATA_WIDTH-1:0] rd_value
);

	logic [iirl_pkg::DATA_WIDTH-1:0] cell_data [iirl_pkg::CAPACITY];
	logic [iirl_pkg::DATA_WIDTH-1:0] tap       [iirl_pkg::TAP_N];
	logic [iirl_pkg::DATA_WIDTH-1:0] part_d    [iirl_pkg::GROUPS];
	logic [iirl_pkg::DATA_WIDTH-1:0] part_q    [iirl_pkg::GROUPS];

	for (genvar i = 0; i < iirl_pkg::CAPACITY; i++) begin : g_cell
		logic [iirl_pkg::DATA_WIDTH-1:0] lower;
		logic [iirl_pkg::DATA_WIDTH-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = cell_data[i-1];
		end

		if (i == iirl_pkg::CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = cell_data[i+1];
		end

		iirl_cell u_cell (
			.clk   (clk),
			.idx   (iirl_pkg::CMP_W'(i)),
			.cmd   (cmd),
			.lower (lower),
			.upper (upper),
			.data  (cell_data[i]),
			.tap   (tap[i])
		);
	end

	for (genvar j = iirl_pkg::CAPACITY; j < iirl_pkg::TAP_N; j++) begin : g_pad
		assign tap[j] = '0;
	end

	always_comb begin
		for (int g = 0; g < iirl_pkg::GROUPS; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < iirl_pkg::GRP_SIZE; k++) begin
				part_d[g] = part_d[g] | tap[g * iirl_pkg::GRP_SIZE + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			for (int g = 0; g < iirl_pkg::GROUPS; g++) begin
				part_q[g] <= part_d[g];
			end
		end
	end

	always_comb begin
		rd_value = '0;
		for (int g = 0; g < iirl_pkg::GROUPS; g++) begin
			rd_value = rd_value | part_q[g];
		end
	end

endmodule

`default_nettype wire
